// ===== sv/acte_pkg.sv =====
// Shared types, codes and BCD helper functions for the alarm clock timer engine.
`default_nettype none

package acte_pkg;

    // Command codes carried by an input word.
    typedef enum logic [1:0] {
        CMD_TENTH = 2'd0,
        CMD_ALERT = 2'd1,
        CMD_LOAD  = 2'd2
    } t_cmd;

    // Destinations of a load command.
    typedef enum logic [2:0] {
        TGT_CLOCK  = 3'd0,
        TGT_SECS   = 3'd1,
        TGT_ALARM1 = 3'd2,
        TGT_ALARM2 = 3'd3,
        TGT_TIMER1 = 3'd4,
        TGT_TIMER2 = 3'd5
    } t_target;

    // Alert waveform selection.
    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_SILENT   = 2'd3
    } t_wave;

    // Tone of the last alert raised.
    typedef enum logic [1:0] {
        TONE_ALARM1 = 2'd0,
        TONE_ALARM2 = 2'd1,
        TONE_TIMER1 = 2'd2,
        TONE_TIMER2 = 2'd3
    } t_tone;

    localparam int unsigned NUM_ALARMS = 2;
    localparam int unsigned NUM_TIMERS = 2;

    // Tenth ticks per timer second, and alert lengths in alert ticks.
    localparam logic [7:0] PRESC_LIMIT      = 8'd10;
    localparam logic [3:0] ALARM_ALERT_SECS = 4'd10;
    localparam logic [3:0] TIMER_ALERT_SECS = 4'd5;

    // Next state of one countdown timer after a tenth tick.
    typedef struct packed {
        logic [15:0] count;
        logic [7:0]  presc;
        logic        expired;
    } t_cd_next;

    // Clamp each of four BCD digits to at most nine.
    function automatic logic [15:0] clamp_digits(input logic [15:0] v);
        logic [15:0] r;
        r = v;
        for (int k = 0; k < 4; k++) begin
            if (v[4*k +: 4] > 4'd9) begin
                r[4*k +: 4] = 4'd9;
            end
        end
        return r;
    endfunction

    // Hours of 24 or more wrap to 00; minutes are kept.
    function automatic logic [15:0] fix_hours(input logic [15:0] v);
        logic [15:0] r;
        r = v;
        if (v[15:12] > 4'd2 || (v[15:12] == 4'd2 && v[11:8] >= 4'd4)) begin
            r = {8'h00, v[7:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/acte_countdown.sv =====
// One MM:SS countdown timer with its free-running prescaler.
`default_nettype none

module acte_countdown
    import acte_pkg::*;
(
    input  wire logic [15:0] i_count,
    input  wire logic [7:0]  i_presc,
    output t_cd_next         o_next
);

    logic [7:0]  presc_inc;
    logic [15:0] dec;

    assign presc_inc = i_presc + 8'd1;

    // BCD decrement of MMSS; seconds tens wrap to five.
    always_comb begin
        dec = i_count;
        if (i_count[3:0] != 4'd0) begin
            dec[3:0] = i_count[3:0] - 4'd1;
        end else begin
            dec[3:0] = 4'd9;
            if (i_count[7:4] != 4'd0) begin
                dec[7:4] = i_count[7:4] - 4'd1;
            end else begin
                dec[7:4] = 4'd5;
                if (i_count[11:8] != 4'd0) begin
                    dec[11:8] = i_count[11:8] - 4'd1;
                end else begin
                    dec[11:8] = 4'd9;
                    if (i_count[15:12] != 4'd0) begin
                        dec[15:12] = i_count[15:12] - 4'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_next.count   = i_count;
        o_next.presc   = presc_inc;
        o_next.expired = 1'b0;
        if (i_count != 16'd0) begin
            if (presc_inc >= PRESC_LIMIT) begin
                o_next.presc = 8'd0;
                o_next.count = dec;
            end
            o_next.expired = (o_next.count == 16'd0);
        end
    end

endmodule

`default_nettype wire

// ===== sv/alarm_clock_timer_engine.sv =====
// Top level of the alarm clock timer engine: handshake, state and step logic.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------------------
//   command  | in        | i_valid / o_stall    | i_cmd, i_alarm1_on, i_alarm2_on,
//            |           |                      | i_load_target, i_load_digits
//   status   | out       | o_valid / i_stall    | o_clock_hhmm, o_clock_sec, o_timer1_left,
//            |           |                      | o_timer2_left, o_wave_select, o_tone_code
//
// A word waits in the input register until the step stage advances and applies it to the
// state, whose registers then show its status word. One word per cycle is sustained while
// the output is not stalled; the limit is the single step stage between the input register
// and the state. The state registers double as the status register: they change only when a
// status word is loaded, so the status payload holds while the output is stalled.
// The input register keeps accepting while the output is stalled until it holds a word;
// o_stall then rises. Reset is synchronous, active low, and needs no clearing pass.
`default_nettype none

module alarm_clock_timer_engine
    import acte_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic        i_alarm1_on,
    input  wire logic        i_alarm2_on,
    input  wire logic [2:0]  i_load_target,
    input  wire logic [15:0] i_load_digits,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_clock_hhmm,
    output logic [11:0]      o_clock_sec,
    output logic [15:0]      o_timer1_left,
    output logic [15:0]      o_timer2_left,
    output logic [1:0]       o_wave_select,
    output logic [1:0]       o_tone_code
);

    // Input register.
    logic        r_in_vld;
    logic [1:0]  r_in_cmd;
    logic        r_in_on1;
    logic        r_in_on2;
    logic [2:0]  r_in_target;
    logic [15:0] r_in_digits;

    // Engine state, also shown as the status word.
    logic                  r_out_vld;
    logic [15:0]           r_hhmm,   n_hhmm;
    logic [7:0]            r_sec,    n_sec;
    logic [3:0]            r_tenths, n_tenths;
    logic [15:0]           r_alarm  [NUM_ALARMS];
    logic [15:0]           n_alarm  [NUM_ALARMS];
    logic [15:0]           r_count  [NUM_TIMERS];
    logic [15:0]           n_count  [NUM_TIMERS];
    logic [7:0]            r_presc  [NUM_TIMERS];
    logic [7:0]            n_presc  [NUM_TIMERS];
    t_wave                 r_wave,   n_wave;
    t_tone                 r_tone,   n_tone;
    logic [3:0]            r_alert_secs, n_alert_secs;
    logic [NUM_ALARMS-1:0] r_muted,  n_muted;

    logic        advance;
    logic        take_in;
    logic [15:0] load_val;
    logic [3:0]  su, st, mu, mt, hu, ht;
    t_cd_next    cd_next [NUM_TIMERS];

    // The step stage moves when the status register is empty or being taken.
    assign advance = !r_out_vld || !i_stall;
    assign o_stall = r_in_vld && !advance;
    assign take_in = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take_in) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_cmd    <= i_cmd;
            r_in_on1    <= i_alarm1_on;
            r_in_on2    <= i_alarm2_on;
            r_in_target <= i_load_target;
            r_in_digits <= i_load_digits;
        end
    end

    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_timer
        acte_countdown u_countdown (
            .i_count (r_count[k]),
            .i_presc (r_presc[k]),
            .o_next  (cd_next[k])
        );
    end

    assign load_val = clamp_digits(r_in_digits);

    always_comb begin
        n_hhmm       = r_hhmm;
        n_sec        = r_sec;
        n_tenths     = r_tenths;
        n_alarm      = r_alarm;
        n_count      = r_count;
        n_presc      = r_presc;
        n_wave       = r_wave;
        n_tone       = r_tone;
        n_alert_secs = r_alert_secs;
        n_muted      = r_muted;
        su = r_sec[3:0];
        st = r_sec[7:4];
        mu = r_hhmm[3:0];
        mt = r_hhmm[7:4];
        hu = r_hhmm[11:8];
        ht = r_hhmm[15:12];

        case (r_in_cmd)
            CMD_TENTH: begin
                // Alarms compare against the clock before it advances; alarm 2 wins
                // over alarm 1, and the timers below win over both.
                if (r_hhmm == r_alarm[0] && r_in_on1 && !r_muted[0]) begin
                    n_wave = WAVE_TRIANGLE;
                    n_tone = TONE_ALARM1;
                end
                if (r_hhmm == r_alarm[1] && r_in_on2 && !r_muted[1]) begin
                    n_wave = WAVE_SQUARE;
                    n_tone = TONE_ALARM2;
                end

                // Clock advance with BCD carries through seconds, minutes and hours.
                n_tenths = r_tenths + 4'd1;
                if (r_tenths >= 4'd9) begin
                    n_tenths = 4'd0;
                    su = r_sec[3:0] + 4'd1;
                    if (su > 4'd9) begin
                        su = 4'd0;
                        st = r_sec[7:4] + 4'd1;
                        if (st > 4'd5) begin
                            // A minute rollover also lifts the alarm mutes.
                            st      = 4'd0;
                            n_muted = '0;
                            mu      = r_hhmm[3:0] + 4'd1;
                            if (mu > 4'd9) begin
                                mu = 4'd0;
                                mt = r_hhmm[7:4] + 4'd1;
                                if (mt > 4'd5) begin
                                    mt = 4'd0;
                                    hu = r_hhmm[11:8] + 4'd1;
                                    if (hu > 4'd9) begin
                                        hu = 4'd0;
                                        ht = r_hhmm[15:12] + 4'd1;
                                    end
                                end
                            end
                            n_hhmm = fix_hours({ht, hu, mt, mu});
                        end
                    end
                    n_sec = {st, su};
                end

                // Prescalers run on every tenth tick; timer 2 is checked last.
                for (int k = 0; k < NUM_TIMERS; k++) begin
                    n_presc[k] = cd_next[k].presc;
                    n_count[k] = cd_next[k].count;
                end
                if (cd_next[0].expired) begin
                    n_wave = WAVE_SINE;
                    n_tone = TONE_TIMER1;
                end
                if (cd_next[1].expired) begin
                    n_wave = WAVE_SINE;
                    n_tone = TONE_TIMER2;
                end
            end
            CMD_ALERT: begin
                // The alert second count runs only while an alert sounds and is not
                // cleared when a new alert starts.
                case (r_wave)
                    WAVE_TRIANGLE, WAVE_SQUARE: begin
                        n_alert_secs = r_alert_secs + 4'd1;
                        if (n_alert_secs >= ALARM_ALERT_SECS) begin
                            n_alert_secs = 4'd0;
                            n_wave       = WAVE_SILENT;
                            if (r_wave == WAVE_TRIANGLE) begin
                                n_muted[0] = 1'b1;
                            end else begin
                                n_muted[1] = 1'b1;
                            end
                        end
                    end
                    WAVE_SINE: begin
                        n_alert_secs = r_alert_secs + 4'd1;
                        if (n_alert_secs >= TIMER_ALERT_SECS) begin
                            n_alert_secs = 4'd0;
                            n_wave       = WAVE_SILENT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_LOAD: begin
                case (r_in_target)
                    TGT_CLOCK:  n_hhmm     = fix_hours(load_val);
                    TGT_SECS:   n_sec      = load_val[15:8];
                    TGT_ALARM1: n_alarm[0] = load_val;
                    TGT_ALARM2: n_alarm[1] = load_val;
                    TGT_TIMER1: n_count[0] = load_val;
                    TGT_TIMER2: n_count[1] = load_val;
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld    <= 1'b0;
            r_hhmm       <= '0;
            r_sec        <= '0;
            r_tenths     <= '0;
            r_alarm      <= '{default: '0};
            r_count      <= '{default: '0};
            r_presc      <= '{default: '0};
            r_wave       <= WAVE_SILENT;
            r_tone       <= TONE_ALARM1;
            r_alert_secs <= '0;
            r_muted      <= '0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_hhmm       <= n_hhmm;
                r_sec        <= n_sec;
                r_tenths     <= n_tenths;
                r_alarm      <= n_alarm;
                r_count      <= n_count;
                r_presc      <= n_presc;
                r_wave       <= n_wave;
                r_tone       <= n_tone;
                r_alert_secs <= n_alert_secs;
                r_muted      <= n_muted;
            end
        end
    end

    assign o_valid       = r_out_vld;
    assign o_clock_hhmm  = r_hhmm;
    assign o_clock_sec   = {r_sec, r_tenths};
    assign o_timer1_left = r_count[0];
    assign o_timer2_left = r_count[1];
    assign o_wave_select = r_wave;
    assign o_tone_code   = r_tone;

endmodule

`default_nettype wire
